// ----- rtl/iwr_pkg.sv -----
// Shared types and codes for the interrupt wait rendezvous core.
package iwr_pkg;

    localparam int PROC_W = 16;
    localparam int ADDR_W = 16;

    typedef enum logic [1:0] {
        OP_EVENT = 2'd0,
        OP_WAIT  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_TIME_NOW  = 3'd0,
        KIND_SUSPENDED = 3'd1,
        KIND_DELIVERED = 3'd2,
        KIND_RESCHED   = 3'd3,
        KIND_BAD_LINE  = 3'd4,
        KIND_LATCHED   = 3'd5,
        KIND_CLR_DONE  = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLR_RD,
        ST_CLR_EM,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/interrupt_wait_rendezvous_core.sv -----
// Interrupt wait rendezvous core: per-line event latch or waiter, memory based.
//
// Each interrupt line holds either a latched event time or one waiting process.
// Latched times and waiter handles/reply addresses live in two single-port
// memories with a registered read; presence and delivery flags are kept
// in flip-flops, so no clearing pass is needed after reset. An event or wait
// beat is accepted with its memory read, then does its read-modify-write and
// result load; op code 3 is absorbed at accept and gives no result. A clear
// is accepted, then walks all LINES entries: an empty line takes a read step
// only, a waiting line a read and then an emit step, and a final done beat
// ends the walk. A new beat is accepted only in the idle state, but a
// finished result may still sit in the output register while the next beat
// is taken. Output stall holds the result, emit and done steps.
module interrupt_wait_rendezvous_core
    import iwr_pkg::*;
#(
    parameter int LINES     = 8,
    parameter int WORD_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_op,
    input  logic [7:0]                  i_line,
    input  logic signed [WORD_BITS-1:0] i_time_ms,
    input  logic [PROC_W-1:0]           i_process_id,
    input  logic [ADDR_W-1:0]           i_reply_addr,

    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [2:0]                  o_kind,
    output logic [2:0]                  o_line_out,
    output logic [PROC_W-1:0]           o_process_out,
    output logic [ADDR_W-1:0]           o_addr_out,
    output logic signed [WORD_BITS-1:0] o_time_out,
    output logic                        o_intr_raised,
    output logic                        o_any_waiting,
    output logic                        o_last
);

    localparam int LW             = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int LINE_TOTAL     = LINES;
    localparam int WAIT_W         = PROC_W + ADDR_W;
    localparam logic [WORD_BITS-1:0] MIN_INT    = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [WORD_BITS-1:0] MIN_INT_P1 = MIN_INT + WORD_BITS'(1);
    localparam logic [LW-1:0]        LAST_IDX   = LW'(LINE_TOTAL - 1);

    // state
    t_state                 r_state, n_state;
    logic [LINES-1:0]       r_pvalid, n_pvalid;
    logic [LINES-1:0]       r_wvalid, n_wvalid;
    logic [LINES-1:0]       r_wdeliv, n_wdeliv;
    logic                   r_intr, n_intr;
    logic [LW-1:0]          r_idx, n_idx;

    // captured beat
    t_op                    r_op;
    logic [LW-1:0]          r_lidx;
    logic                   r_bad;
    logic [WORD_BITS-1:0]   r_time;
    logic [PROC_W-1:0]      r_proc;
    logic [ADDR_W-1:0]      r_addr;

    // memories
    logic [WORD_BITS-1:0]   r_pend_mem [LINES];
    logic [WAIT_W-1:0]      r_wait_mem [LINES];
    logic [WORD_BITS-1:0]   r_pend_rd;
    logic [WAIT_W-1:0]      r_wait_rd;
    logic [LW-1:0]          rd_addr;
    logic                   pend_we;
    logic [WORD_BITS-1:0]   pend_wd;
    logic                   wait_we;

    // output register
    logic                   r_ov, n_ov;
    logic                   out_load;
    t_kind                  r_kind, n_kind;
    logic [2:0]             r_line_out, n_line_out;
    logic [PROC_W-1:0]      r_proc_out, n_proc_out;
    logic [ADDR_W-1:0]      r_addr_out, n_addr_out;
    logic [WORD_BITS-1:0]   r_time_out, n_time_out;
    logic                   r_intr_out, n_intr_out;
    logic                   r_any_out, n_any_out;
    logic                   r_last, n_last;

    logic                   in_acc;
    logic                   out_free;
    logic [WORD_BITS-1:0]   t_adj;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_ov || !i_out_stall;
    assign t_adj      = (r_time == MIN_INT) ? MIN_INT_P1 : r_time;

    always_comb begin
        case (r_state)
            ST_IDLE:   rd_addr = i_line[LW-1:0];
            ST_EXEC:   rd_addr = r_lidx;
            default:   rd_addr = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pend_we) begin
            r_pend_mem[r_lidx] <= pend_wd;
        end
        r_pend_rd <= r_pend_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wait_we) begin
            r_wait_mem[r_lidx] <= {r_proc, r_addr};
        end
        r_wait_rd <= r_wait_mem[rd_addr];
    end

    always_comb begin
        n_state    = r_state;
        n_pvalid   = r_pvalid;
        n_wvalid   = r_wvalid;
        n_wdeliv   = r_wdeliv;
        n_intr     = r_intr;
        n_idx      = r_idx;
        n_ov       = r_ov && i_out_stall;
        out_load   = 1'b0;
        n_kind     = KIND_TIME_NOW;
        n_line_out = '0;
        n_proc_out = '0;
        n_addr_out = '0;
        n_time_out = '0;
        n_intr_out = 1'b0;
        n_any_out  = 1'b0;
        n_last     = 1'b1;
        pend_we    = 1'b0;
        pend_wd    = t_adj;
        wait_we    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (t_op'(i_op))
                        OP_CLEAR: begin
                            n_idx   = '0;
                            n_state = ST_CLR_RD;
                        end
                        OP_NONE:  n_state = ST_IDLE;
                        default:  n_state = ST_EXEC;
                    endcase
                end
            end

            ST_EXEC: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_ov       = 1'b1;
                    n_state    = ST_IDLE;
                    n_line_out = 3'(r_lidx);
                    if (r_bad) begin
                        n_kind     = KIND_BAD_LINE;
                        n_line_out = '0;
                    end else if (r_op == OP_EVENT) begin
                        if (r_wvalid[r_lidx]) begin
                            if (!r_wdeliv[r_lidx]) begin
                                n_wdeliv[r_lidx] = 1'b1;
                                n_intr           = 1'b1;
                                n_kind           = KIND_DELIVERED;
                                n_proc_out       = r_wait_rd[WAIT_W-1:ADDR_W];
                                n_addr_out       = r_wait_rd[ADDR_W-1:0];
                                n_time_out       = r_time;
                            end else begin
                                n_kind = KIND_LATCHED;
                            end
                        end else begin
                            pend_we          = 1'b1;
                            n_pvalid[r_lidx] = 1'b1;
                            n_kind           = KIND_LATCHED;
                            n_time_out       = t_adj;
                        end
                    end else begin
                        if (r_pvalid[r_lidx]) begin
                            n_pvalid[r_lidx] = 1'b0;
                            n_kind           = KIND_TIME_NOW;
                            n_time_out       = r_pend_rd;
                        end else begin
                            wait_we          = 1'b1;
                            n_wvalid[r_lidx] = 1'b1;
                            n_wdeliv[r_lidx] = 1'b0;
                            n_kind           = KIND_SUSPENDED;
                            n_proc_out       = r_proc;
                            n_addr_out       = r_addr;
                        end
                    end
                    n_intr_out = n_intr;
                    n_any_out  = |n_wvalid;
                end
            end

            ST_CLR_RD: begin
                if (r_wvalid[r_idx]) begin
                    n_state = ST_CLR_EM;
                end else if (r_idx == LAST_IDX) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + LW'(1);
                end
            end

            ST_CLR_EM: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    n_ov            = 1'b1;
                    n_kind          = KIND_RESCHED;
                    n_line_out      = 3'(r_idx);
                    n_proc_out      = r_wait_rd[WAIT_W-1:ADDR_W];
                    n_addr_out      = r_wait_rd[ADDR_W-1:0];
                    n_last          = 1'b0;
                    n_wvalid[r_idx] = 1'b0;
                    n_wdeliv[r_idx] = 1'b0;
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_DONE;
                    end else begin
                        n_idx   = r_idx + LW'(1);
                        n_state = ST_CLR_RD;
                    end
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_ov     = 1'b1;
                    n_kind   = KIND_CLR_DONE;
                    n_intr   = 1'b0;
                    n_state  = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pvalid <= '0;
            r_wvalid <= '0;
            r_wdeliv <= '0;
            r_intr   <= 1'b0;
            r_idx    <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pvalid <= n_pvalid;
            r_wvalid <= n_wvalid;
            r_wdeliv <= n_wdeliv;
            r_intr   <= n_intr;
            r_idx    <= n_idx;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= t_op'(i_op);
            r_lidx <= i_line[LW-1:0];
            r_bad  <= (i_line >= 8'(LINE_TOTAL));
            r_time <= i_time_ms;
            r_proc <= i_process_id;
            r_addr <= i_reply_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_kind     <= n_kind;
            r_line_out <= n_line_out;
            r_proc_out <= n_proc_out;
            r_addr_out <= n_addr_out;
            r_time_out <= n_time_out;
            r_intr_out <= n_intr_out;
            r_any_out  <= n_any_out;
            r_last     <= n_last;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_kind        = r_kind;
    assign o_line_out    = r_line_out;
    assign o_process_out = r_proc_out;
    assign o_addr_out    = r_addr_out;
    assign o_time_out    = r_time_out;
    assign o_intr_raised = r_intr_out;
    assign o_any_waiting = r_any_out;
    assign o_last        = r_last;

    // a line never holds a latched time and a waiter together
    a_latch_xor_waiter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pvalid & r_wvalid) == '0)
        else $error("line holds both latched time and waiter");

    a_deliv_needs_waiter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wdeliv & ~r_wvalid) == '0)
        else $error("delivered mark on line without waiter");

    a_resched_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_RESCHED) |-> !o_last && !o_intr_raised)
        else $error("reschedule beat marked last or with flag raised");

    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_CLR_DONE) |-> o_last && !o_any_waiting)
        else $error("clear done beat with waiters left");

    a_deliv_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_DELIVERED) |-> o_intr_raised && o_any_waiting)
        else $error("delivery without raised flag");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (r_wvalid == '0))
        else $error("waiter left after clear walk");

endmodule
